// ===== sv/cartridge_bank_mapper_defines.svh =====
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_defines.svh
// Assertion macros used by the bank mapper RTL.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_MAPPER_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_DEFINES_SVH

// Checks a property at every rising clock edge outside reset.
`define CBM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define CBM_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// cbm_pkg
// Access codes, constants and lookup tables of the cartridge bank mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbm_pkg;

    typedef logic [1:0]  kind_t;
    typedef logic [15:0] addr_t;
    typedef logic [7:0]  byte_t;
    typedef logic [18:0] offset_t;

    localparam kind_t KIND_WRITE = 2'd0;
    localparam kind_t KIND_READ  = 2'd1;
    localparam kind_t KIND_PROG  = 2'd2;

    localparam int unsigned NUM_BANK_REGS = 8;

    localparam byte_t REG0_SMALL_INIT = 8'h0E;
    localparam byte_t REG0_BIG_INIT   = 8'h00;
    localparam byte_t OPEN_BUS_MASK   = 8'hD8;
    localparam logic [3:0] REG_WINDOW_PAGE = 4'h5;

    // Small-mode bank pair table, 128 entries. Odd rows of sixteen alternate
    // between two fixed pairs; even rows count the high bank over index bits
    // 1..0, with the tail of row six using bank zero as the upper bank.
    function automatic byte_t small_bank_entry(input logic [6:0] idx);
        byte_t e;
        e = 8'h00;
        if (idx[4])
        begin
            if (idx[0])
                e = 8'h67;
            else if (idx[5])
                e = 8'h47;
            else
                e = 8'h45;
        end
        else
        begin
            e[5:4] = idx[1:0];
            if (!idx[6])
                e[3:0] = 4'h3;
            else if (idx[5] && idx[3] && idx[2])
                e[3:0] = 4'h0;
            else
                e[3:0] = 4'h2;
        end
        return e;
    endfunction

    // Protection bits returned on register reads.
    function automatic byte_t prot_entry(input logic [3:0] idx);
        byte_t v;
        unique case (idx)
            4'd1:    v = 8'h09;
            4'd7:    v = 8'h20;
            4'd8:    v = 8'h04;
            4'd15:   v = 8'h02;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/cbm_prog_map.sv =====
// ----------------------------------------------------------------------------
// cbm_prog_map
// Translates a program-space address to a ROM byte offset from register 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbm_prog_map (
    input  cbm_pkg::addr_t   address,
    input  cbm_pkg::byte_t   reg0,
    input  logic             big_mode,
    output cbm_pkg::offset_t rom_offset
);
    import cbm_pkg::*;

    byte_t   entry;
    offset_t small_off;
    offset_t big_off;

    always_comb
    begin
        entry = small_bank_entry(reg0[6:0]);
        if (!address[14])
            small_off = {1'b0, entry[7:4], address[13:0]};
        else
            small_off = {1'b0, entry[3:0], address[13:0]};
    end

    always_comb
    begin
        priority if (reg0[4])
            big_off = {1'b0, reg0[2:0], address[14:0]};
        else if (reg0[6] && (address[14:13] == 2'b00))
            big_off = {1'b1, reg0[5], reg0[3:0], address[12:0]};
        else
            // Fixed 1K window picked by address bits 14..10.
            big_off = {1'b1, address[14:10], 3'b111, address[9:0]};
    end

    always_comb
    begin
        if (!address[15])
            rom_offset = '0;
        else if (big_mode)
            rom_offset = big_off;
        else
            rom_offset = small_off;
    end

endmodule

// ===== sv/cartridge_bank_mapper.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_mapper
// Bank register file, register reads and program address translation.
// ----------------------------------------------------------------------------
// The mapper takes one bus access word per clock while in_ready is high. An
// accepted word sits in the input register, where the bank registers are
// read and written and the ROM offset is formed, and moves to the result
// register as soon as that register is free; it stays there until taken.
// The input stalls only while both registers are full and the result is not
// taken. Bank register writes take effect as the word moves to the result
// register, so a following access sees them. The mode write resets register
// 0 and must be issued only while no access is in flight.
`timescale 1ns / 1ps

`include "cartridge_bank_mapper_defines.svh"

module cartridge_bank_mapper (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cbm_pkg::kind_t    kind,
    input  cbm_pkg::addr_t    address,
    input  cbm_pkg::byte_t    data,
    input  cbm_pkg::byte_t    open_bus,
    output logic              out_valid,
    input  logic              out_ready,
    output cbm_pkg::byte_t    read_data,
    output cbm_pkg::offset_t  rom_offset,
    output logic              mirror_horizontal,
    output logic              alt_mode_flag,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              big_bank_mode
);
    import cbm_pkg::*;

    logic    s1_valid_reg;
    kind_t   s1_kind_reg;
    addr_t   s1_addr_reg;
    byte_t   s1_data_reg;
    byte_t   s1_ob_reg;

    byte_t   bank_regs_reg [NUM_BANK_REGS];
    logic    mode_reg;

    logic    out_valid_reg;
    byte_t   read_data_reg;
    offset_t rom_offset_reg;
    logic    mirror_reg;
    logic    alt_reg;

    logic    in_fire;
    logic    out_free;
    logic    s1_fire;
    logic    in_window;
    logic    wr_hit;
    logic [2:0] wr_idx;
    byte_t   reg0_next;
    byte_t   read_data_next;
    offset_t prog_off;
    offset_t rom_offset_next;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign in_fire  = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign in_window = (s1_addr_reg[15:12] == REG_WINDOW_PAGE);
    assign wr_idx    = s1_addr_reg[10:8];
    assign wr_hit    = (s1_kind_reg == KIND_WRITE) && in_window;
    assign reg0_next = (wr_hit && (wr_idx == 3'd0)) ? s1_data_reg : bank_regs_reg[0];

    cbm_prog_map u_prog_map (
        .address    (s1_addr_reg),
        .reg0       (bank_regs_reg[0]),
        .big_mode   (mode_reg),
        .rom_offset (prog_off)
    );

    always_comb
    begin
        read_data_next  = '0;
        rom_offset_next = '0;
        unique case (s1_kind_reg)
            KIND_READ:
            begin
                // Outside the window nothing drives the bus.
                if (in_window)
                    read_data_next = (s1_ob_reg & OPEN_BUS_MASK)
                                   | prot_entry(bank_regs_reg[4][7:4]);
                else
                    read_data_next = s1_ob_reg;
            end
            KIND_PROG:  rom_offset_next = prog_off;
            default:    ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_kind_reg <= kind;
            s1_addr_reg <= address;
            s1_data_reg <= data;
            s1_ob_reg   <= open_bus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            bank_regs_reg[0] <= REG0_SMALL_INIT;
            for (int i = 1; i < NUM_BANK_REGS; i++)
                bank_regs_reg[i] <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg         <= big_bank_mode;
            bank_regs_reg[0] <= big_bank_mode ? REG0_BIG_INIT : REG0_SMALL_INIT;
        end
        else if (s1_fire && wr_hit)
        begin
            bank_regs_reg[wr_idx] <= s1_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            read_data_reg  <= read_data_next;
            rom_offset_reg <= rom_offset_next;
            mirror_reg     <= mode_reg && (reg0_next[4:3] == 2'b11);
            alt_reg        <= reg0_next[7];
        end
    end

    assign out_valid         = out_valid_reg;
    assign read_data         = read_data_reg;
    assign rom_offset        = rom_offset_reg;
    assign mirror_horizontal = mirror_reg;
    assign alt_mode_flag     = alt_reg;

    `CBM_ASSERT(a_empty_stage_ready, !s1_valid_reg |-> in_ready, "input stage empty but not ready")
    `CBM_ASSERT_NEXT(a_reg4_write, s1_fire && wr_hit && (wr_idx == 3'd4), bank_regs_reg[4] == $past(s1_data_reg), "bank register 4 write lost")
    `CBM_ASSERT_NEXT(a_low_prog_zero, s1_fire && (s1_kind_reg == KIND_PROG) && !s1_addr_reg[15], rom_offset == '0, "program read below 0x8000 gave an offset")

endmodule
